FILE: hw/rtl/apmq_pkg.sv
// Package for the activity priority MRU queue: opcodes, class codes, the
// controller state type and the command struct broadcast to the entry cells.
// Depends on nothing; used by every other file of the block.
package apmq_pkg;

  localparam int unsigned CLS_W = 3;

  // Opcodes of an input item.
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Priority classes, best first, and the code for an entry that is in none.
  localparam logic [CLS_W-1:0] CLS_DLG_HIGHLIGHT = 3'd0;
  localparam logic [CLS_W-1:0] CLS_DLG_ACTIVITY  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_CHN_HIGHLIGHT = 3'd2;
  localparam logic [CLS_W-1:0] CLS_CHN_MESSAGE   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_CHN_DATA      = 3'd4;
  localparam logic [CLS_W-1:0] NO_CLASS          = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_SEARCH,
    S_TAKE
  } apmq_state_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic             do_take;
    logic             do_put;
    logic [CLS_W-1:0] old_cls;
    logic [CLS_W-1:0] new_cls;
  } apmq_cmd_t;

  // Class that an update gives: highlight beats message, message beats data.
  function automatic logic [CLS_W-1:0] classify(input logic dialog, input logic hi,
                                                input logic msg, input logic dat);
    logic [CLS_W-1:0] c;
    c = NO_CLASS;
    if (hi) begin
      c = dialog ? CLS_DLG_HIGHLIGHT : CLS_CHN_HIGHLIGHT;
    end else if (msg) begin
      c = dialog ? CLS_DLG_ACTIVITY : CLS_CHN_MESSAGE;
    end else if (dat) begin
      c = dialog ? CLS_DLG_ACTIVITY : CLS_CHN_DATA;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/apmq_cell.sv
// One entry cell of the activity priority MRU queue: holds the entry's class
// and rank, applies broadcast commands and takes one step of the pop search.
// Depends on apmq_pkg.
module apmq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 5,
  parameter int unsigned RW    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  apmq_pkg::apmq_cmd_t       cmd,
  input  logic [IW-1:0]             cmd_id,
  input  logic [RW-1:0]             cmd_rank,
  output logic [apmq_pkg::CLS_W-1:0] look_cls,
  output logic [RW-1:0]             look_rank,
  input  logic                      elig,
  input  logic                      cin_vld,
  input  logic [apmq_pkg::CLS_W-1:0] cin_cls,
  input  logic [RW-1:0]             cin_rank,
  input  logic [IW-1:0]             cin_id,
  output logic                      cout_vld,
  output logic [apmq_pkg::CLS_W-1:0] cout_cls,
  output logic [RW-1:0]             cout_rank,
  output logic [IW-1:0]             cout_id
);

  logic [apmq_pkg::CLS_W-1:0] cls_r, cls_nxt;
  logic [RW-1:0]              rank_r, rank_nxt;
  logic                       cvld_r, cvld_nxt;
  logic [apmq_pkg::CLS_W-1:0] ccls_r, ccls_nxt;
  logic [RW-1:0]              crank_r, crank_nxt;
  logic [IW-1:0]              cid_r, cid_nxt;
  logic                       mine, own_ok, better;

  assign mine      = (cmd_id == IW'(INDEX));
  assign look_cls  = mine ? cls_r : '0;
  assign look_rank = mine ? rank_r : '0;

  always_comb begin
    cls_nxt  = cls_r;
    rank_nxt = rank_r;
    if (mine) begin
      if (cmd.do_put) begin
        cls_nxt  = cmd.new_cls;
        rank_nxt = '0;
      end else if (cmd.do_take) begin
        cls_nxt = apmq_pkg::NO_CLASS;
      end
    end else begin
      // Taking out closes the gap behind the entry; putting in pushes the class back.
      if (cmd.do_take && cls_r == cmd.old_cls && rank_r > cmd_rank) begin
        rank_nxt = rank_nxt - RW'(1);
      end
      if (cmd.do_put && cls_r == cmd.new_cls) begin
        rank_nxt = rank_nxt + RW'(1);
      end
    end
  end

  // Search step: keep the better of the incoming candidate and this entry.
  always_comb begin
    own_ok = elig && (cls_r != apmq_pkg::NO_CLASS);
    better = own_ok && (!cin_vld || cls_r < cin_cls ||
                        (cls_r == cin_cls && rank_r < cin_rank));
    cvld_nxt  = better ? 1'b1 : cin_vld;
    ccls_nxt  = better ? cls_r : cin_cls;
    crank_nxt = better ? rank_r : cin_rank;
    cid_nxt   = better ? IW'(INDEX) : cin_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r  <= apmq_pkg::NO_CLASS;
      rank_r <= RW'(INDEX);
      cvld_r <= 1'b0;
    end else begin
      cls_r  <= cls_nxt;
      rank_r <= rank_nxt;
      cvld_r <= cvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ccls_r  <= ccls_nxt;
    crank_r <= crank_nxt;
    cid_r   <= cid_nxt;
  end

  assign cout_vld  = cvld_r;
  assign cout_cls  = ccls_r;
  assign cout_rank = crank_r;
  assign cout_id   = cid_r;

endmodule

FILE: hw/rtl/activity_priority_mru_queue.sv
// Top level of the activity priority MRU queue: controller, command broadcast
// and the row of entry cells that forms the pop search chain.
// Depends on apmq_pkg and apmq_cell.
//
//  Channel  Ports                                       Handshake
//  input    in_opcode, in_entry_id, in_is_dialog,       start high while busy low
//           in_flag_*, in_eligible_mask
//  result   out_found, out_chosen_id, out_chosen_class  out_valid, one cycle
//
// An update or a remove, once accepted, looks up the entry's present class and
// rank in S_LOOK, then applies the change in every cell in S_APPLY.
// A pop, once accepted, walks the running best candidate along the row, one
// cell per cycle, then takes the winner out in S_TAKE; the result shows on the
// cycle after that, while busy is low again.
// An item with an unused opcode, or an update or remove of an entry at or
// beyond MAX_SESSIONS, is accepted and dropped without raising busy.
// Reset is synchronous: every entry leaves its class at once, no sweep needed.
// The receiver cannot stall; every result is taken in its one cycle.
module activity_priority_mru_queue #(
  parameter int unsigned MAX_SESSIONS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [4:0]  in_entry_id,
  input  logic        in_is_dialog,
  input  logic        in_flag_highlight,
  input  logic        in_flag_message,
  input  logic        in_flag_data,
  input  logic [31:0] in_eligible_mask,
  output logic        out_valid,
  output logic        out_found,
  output logic [4:0]  out_chosen_id,
  output logic [2:0]  out_chosen_class
);

  localparam int unsigned IW = $clog2(MAX_SESSIONS);
  localparam int unsigned RW = $clog2(MAX_SESSIONS);
  localparam int unsigned CW = apmq_pkg::CLS_W;

  apmq_pkg::apmq_state_t state_r, state_nxt;

  logic [IW-1:0] id_r;
  logic [CW-1:0] nc_r;
  logic [CW-1:0] oc_r;
  logic [RW-1:0] orank_r;
  logic [31:0]   mask_r;
  logic [IW-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r;
  logic [4:0]    out_id_r;
  logic [CW-1:0] out_cls_r;

  logic          accept, id_ok, skip;
  apmq_pkg::apmq_cmd_t cmd;
  logic [IW-1:0] cmd_id;
  logic [RW-1:0] cmd_rank;

  logic [CW-1:0] look_cls  [MAX_SESSIONS];
  logic [RW-1:0] look_rank [MAX_SESSIONS];
  logic [CW-1:0] look_cls_any;
  logic [RW-1:0] look_rank_any;
  logic          elig [MAX_SESSIONS];

  // Candidate chain; link 0 feeds "no candidate" into the first cell.
  logic          ch_vld  [MAX_SESSIONS+1];
  logic [CW-1:0] ch_cls  [MAX_SESSIONS+1];
  logic [RW-1:0] ch_rank [MAX_SESSIONS+1];
  logic [IW-1:0] ch_id   [MAX_SESSIONS+1];

  logic          win_vld;
  logic [CW-1:0] win_cls;
  logic [RW-1:0] win_rank;
  logic [IW-1:0] win_id;

  assign busy   = (state_r != apmq_pkg::S_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (32'(in_entry_id) < MAX_SESSIONS);

  assign ch_vld[0]  = 1'b0;
  assign ch_cls[0]  = apmq_pkg::NO_CLASS;
  assign ch_rank[0] = '0;
  assign ch_id[0]   = '0;

  assign win_vld  = ch_vld[MAX_SESSIONS];
  assign win_cls  = ch_cls[MAX_SESSIONS];
  assign win_rank = ch_rank[MAX_SESSIONS];
  assign win_id   = ch_id[MAX_SESSIONS];

  generate
    for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_cell
      // Only the first 32 entries have a bit in the eligibility mask.
      if (g < 32) begin : g_mask
        assign elig[g] = mask_r[g];
      end else begin : g_nomask
        assign elig[g] = 1'b0;
      end

      apmq_cell #(
        .INDEX (g),
        .IW    (IW),
        .RW    (RW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_id    (cmd_id),
        .cmd_rank  (cmd_rank),
        .look_cls  (look_cls[g]),
        .look_rank (look_rank[g]),
        .elig      (elig[g]),
        .cin_vld   (ch_vld[g]),
        .cin_cls   (ch_cls[g]),
        .cin_rank  (ch_rank[g]),
        .cin_id    (ch_id[g]),
        .cout_vld  (ch_vld[g+1]),
        .cout_cls  (ch_cls[g+1]),
        .cout_rank (ch_rank[g+1]),
        .cout_id   (ch_id[g+1])
      );
    end
  endgenerate

  // Only the addressed cell drives a non-zero lookup value, so an OR gathers it.
  always_comb begin
    look_cls_any  = '0;
    look_rank_any = '0;
    for (int i = 0; i < MAX_SESSIONS; i++) begin
      look_cls_any  = look_cls_any | look_cls[i];
      look_rank_any = look_rank_any | look_rank[i];
    end
  end

  // An update or a remove that leaves the entry where it already is does nothing.
  assign skip = (oc_r == nc_r) && ((nc_r == apmq_pkg::NO_CLASS) || (orank_r == '0));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '{do_take: 1'b0, do_put: 1'b0,
                      old_cls: apmq_pkg::NO_CLASS, new_cls: apmq_pkg::NO_CLASS};
    cmd_id        = id_r;
    cmd_rank      = orank_r;
    case (state_r)
      apmq_pkg::S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_opcode == apmq_pkg::OP_POP) begin
            state_nxt = apmq_pkg::S_SEARCH;
          end else if ((in_opcode == apmq_pkg::OP_UPDATE ||
                        in_opcode == apmq_pkg::OP_REMOVE) && id_ok) begin
            state_nxt = apmq_pkg::S_LOOK;
          end
        end
      end
      apmq_pkg::S_LOOK: begin
        state_nxt = apmq_pkg::S_APPLY;
      end
      apmq_pkg::S_APPLY: begin
        cmd.do_take = !skip && (oc_r != apmq_pkg::NO_CLASS);
        cmd.do_put  = !skip && (nc_r != apmq_pkg::NO_CLASS);
        cmd.old_cls = oc_r;
        cmd.new_cls = nc_r;
        state_nxt   = apmq_pkg::S_IDLE;
      end
      apmq_pkg::S_SEARCH: begin
        // The last cell holds the winner once the chain has been walked end to end.
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == IW'(MAX_SESSIONS - 1)) begin
          state_nxt = apmq_pkg::S_TAKE;
        end
      end
      apmq_pkg::S_TAKE: begin
        cmd.do_take   = win_vld;
        cmd.old_cls   = win_cls;
        cmd_id        = win_id;
        cmd_rank      = win_rank;
        out_valid_nxt = 1'b1;
        state_nxt     = apmq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = apmq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apmq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= IW'(in_entry_id);
      mask_r <= in_eligible_mask;
      nc_r   <= (in_opcode == apmq_pkg::OP_REMOVE) ? apmq_pkg::NO_CLASS :
                apmq_pkg::classify(in_is_dialog, in_flag_highlight,
                                   in_flag_message, in_flag_data);
    end
    if (state_r == apmq_pkg::S_LOOK) begin
      oc_r    <= look_cls_any;
      orank_r <= look_rank_any;
    end
    if (state_r == apmq_pkg::S_TAKE) begin
      out_found_r <= win_vld;
      out_id_r    <= win_vld ? 5'(win_id) : 5'd0;
      out_cls_r   <= win_vld ? win_cls : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chosen_id    = out_id_r;
  assign out_chosen_class = out_cls_r;

endmodule

FILE: hw/rtl/apmq_checker.sv
// Port-level checker for the activity priority MRU queue, bound to the top level.
// Depends on apmq_pkg and the top level activity_priority_mru_queue.
module apmq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_found,
  input logic [4:0] out_chosen_id,
  input logic [2:0] out_chosen_class
);

  // Reset leaves the block idle with no result showing.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // An empty pop reports zeros.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_chosen_id == 5'd0 && out_chosen_class == 3'd0)
    else $error("empty pop result not zero");

  // A found entry comes from a real class.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_chosen_class < apmq_pkg::NO_CLASS)
    else $error("popped class out of range");

  // An accepted pop keeps the block busy on the next cycle.
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == apmq_pkg::OP_POP |=> busy && !out_valid)
    else $error("pop did not occupy the block");

  // Results come one per pop; the result strobe is never high back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind activity_priority_mru_queue apmq_checker u_apmq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_found        (out_found),
  .out_chosen_id    (out_chosen_id),
  .out_chosen_class (out_chosen_class)
);

FILE: tb/activity_priority_mru_queue_tb.sv
// Self-checking testbench for activity_priority_mru_queue: a short directed run over every
// class, opcode and corner of the store, then weighted random traffic against a local predictor.
// Depends on apmq_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module activity_priority_mru_queue_tb;

  localparam int unsigned SESSIONS = 32;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One pop answer as the block should report it.
  typedef struct packed {
    logic       found;
    logic [4:0] id;
    logic [2:0] cls;
  } pop_answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [4:0]  in_entry_id;
  logic        in_is_dialog;
  logic        in_flag_highlight;
  logic        in_flag_message;
  logic        in_flag_data;
  logic [31:0] in_eligible_mask;
  logic        out_valid;
  logic        out_found;
  logic [4:0]  out_chosen_id;
  logic [2:0]  out_chosen_class;

  // Predicted store: the class each entry sits in and its place within that class.
  logic [2:0] seat_class [SESSIONS];
  logic [4:0] seat_rank  [SESSIONS];

  // Answers of accepted pops that have not yet come out of the block, oldest first.
  pop_answer_t pop_answers [$];

  int unsigned faults;
  int unsigned stall_cycles;
  // When set, the sender never pauses between items.
  bit          steady;

  activity_priority_mru_queue #(
    .MAX_SESSIONS(SESSIONS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_entry_id      (in_entry_id),
    .in_is_dialog     (in_is_dialog),
    .in_flag_highlight(in_flag_highlight),
    .in_flag_message  (in_flag_message),
    .in_flag_data     (in_flag_data),
    .in_eligible_mask (in_eligible_mask),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_id    (out_chosen_id),
    .out_chosen_class (out_chosen_class)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Takes an entry out of its class and closes the gap it leaves behind it.
  task automatic unlink_entry(input int unsigned id);
    logic [2:0] c;
    logic [4:0] r;
    c = seat_class[id];
    r = seat_rank[id];
    if (c != apmq_pkg::NO_CLASS) begin
      for (int i = 0; i < SESSIONS; i++) begin
        if (i != id && seat_class[i] == c && seat_rank[i] > r) begin
          seat_rank[i] = seat_rank[i] - 5'd1;
        end
      end
      seat_class[id] = apmq_pkg::NO_CLASS;
    end
  endtask

  // Places an entry at the front of a class, pushing the others one place back.
  task automatic link_front(input int unsigned id, input logic [2:0] c);
    for (int i = 0; i < SESSIONS; i++) begin
      if (i != id && seat_class[i] == c) begin
        seat_rank[i] = seat_rank[i] + 5'd1;
      end
    end
    seat_class[id] = c;
    seat_rank[id]  = 5'd0;
  endtask

  // Works out what one accepted item does to the store and queues the answer of a pop.
  task automatic apply_item(input logic [1:0] op, input logic [4:0] id, input logic dialog,
                            input logic hi, input logic msg, input logic dat,
                            input logic [31:0] mask);
    logic [2:0]  target;
    pop_answer_t answer;
    bit          have;
    int unsigned best;
    case (op)
      apmq_pkg::OP_UPDATE: begin
        // Highlight outranks message, and message outranks plain data.
        if (hi) begin
          target = dialog ? apmq_pkg::CLS_DLG_HIGHLIGHT : apmq_pkg::CLS_CHN_HIGHLIGHT;
        end else if (msg) begin
          target = dialog ? apmq_pkg::CLS_DLG_ACTIVITY : apmq_pkg::CLS_CHN_MESSAGE;
        end else if (dat) begin
          target = dialog ? apmq_pkg::CLS_DLG_ACTIVITY : apmq_pkg::CLS_CHN_DATA;
        end else begin
          target = apmq_pkg::NO_CLASS;
        end
        // An entry already at the front of its new class, or one that stays out of
        // every class, is left exactly as it is.
        if (!(seat_class[id] == target &&
              (target == apmq_pkg::NO_CLASS || seat_rank[id] == 5'd0))) begin
          unlink_entry(id);
          if (target != apmq_pkg::NO_CLASS) begin
            link_front(id, target);
          end
        end
      end
      apmq_pkg::OP_POP: begin
        answer = '0;
        for (int c = 0; c < apmq_pkg::NO_CLASS && !answer.found; c++) begin
          have = 1'b0;
          best = 0;
          for (int i = 0; i < SESSIONS; i++) begin
            if (seat_class[i] == c && mask[i] &&
                (!have || seat_rank[i] < seat_rank[best])) begin
              have = 1'b1;
              best = i;
            end
          end
          if (have) begin
            unlink_entry(best);
            answer.found = 1'b1;
            answer.id    = best[4:0];
            answer.cls   = c[2:0];
          end
        end
        pop_answers.push_back(answer);
      end
      apmq_pkg::OP_REMOVE: begin
        unlink_entry(id);
      end
      default: begin
        // The spare opcode is swallowed without any effect.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: takes accepted items into the predictor and checks each result.
  // Both are sampled at the rising edge, so they see the values of the cycle
  // that the edge closes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pop_answer_t want;
    if (rst_n) begin
      // The result is checked before a new item is taken in, so that an answer
      // still in flight is matched against the older expectation.
      if (out_valid) begin
        if (pop_answers.size() == 0) begin
          faults++;
          if (faults <= 10) begin
            $display("unexpected result: found %0d id %0d class %0d",
                     out_found, out_chosen_id, out_chosen_class);
          end
        end else begin
          want = pop_answers.pop_front();
          if (out_found !== want.found || out_chosen_id !== want.id ||
              out_chosen_class !== want.cls) begin
            faults++;
            if (faults <= 10) begin
              $display("pop mismatch: expected found %0d id %0d class %0d, got %0d %0d %0d",
                       want.found, want.id, want.cls,
                       out_found, out_chosen_id, out_chosen_class);
            end
          end
        end
      end
      if (start && !busy) begin
        apply_item(in_opcode, in_entry_id, in_is_dialog, in_flag_highlight,
                   in_flag_message, in_flag_data, in_eligible_mask);
      end
      // The watchdog counts cycles in which neither side moves anything.
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Ends a run that has hung: a pop is the slowest item by far, so once the
  // quiet count reaches STALL_LIMIT the handshake can only have stopped.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("activity_priority_mru_queue_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Presents one item at a falling edge and holds it until the block takes it.
  // Start is left high afterwards so that back-to-back items need no gap.
  task automatic send_item(input logic [1:0] op, input logic [4:0] id, input logic dialog,
                           input logic hi, input logic msg, input logic dat,
                           input logic [31:0] mask);
    if (!steady && $urandom_range(0, 99) < 19) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_opcode         <= op;
    in_entry_id       <= id;
    in_is_dialog      <= dialog;
    in_flag_highlight <= hi;
    in_flag_message   <= msg;
    in_flag_data      <= dat;
    in_eligible_mask  <= mask;
    start             <= 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Fields that an operation ignores still carry random values, so the block
  // is seen to ignore them.
  task automatic do_update(input logic [4:0] id, input logic dialog,
                           input logic hi, input logic msg, input logic dat);
    send_item(apmq_pkg::OP_UPDATE, id, dialog, hi, msg, dat, $urandom);
  endtask

  task automatic do_pop(input logic [31:0] mask);
    send_item(apmq_pkg::OP_POP, 5'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom), mask);
  endtask

  task automatic do_remove(input logic [4:0] id);
    send_item(apmq_pkg::OP_REMOVE, id, 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops on an empty store must report nothing found, with or without a mask.
  task automatic test_empty_pops();
    do_pop(32'hFFFF_FFFF);
    do_pop(32'h0000_0000);
  endtask

  // At least one entry per class, using both extreme entry indexes; the last update sets
  // every flag at once to show that highlight wins.
  task automatic test_classification();
    do_update(5'd31, 1'b1, 1'b1, 1'b0, 1'b0);
    do_update(5'd0,  1'b1, 1'b0, 1'b1, 1'b0);
    do_update(5'd5,  1'b1, 1'b0, 1'b0, 1'b1);
    do_update(5'd9,  1'b0, 1'b1, 1'b0, 1'b0);
    do_update(5'd12, 1'b0, 1'b0, 1'b1, 1'b0);
    do_update(5'd17, 1'b0, 1'b0, 1'b0, 1'b1);
    do_update(5'd20, 1'b0, 1'b1, 1'b1, 1'b1);
  endtask

  // Refreshing an entry already at the front, clearing an entry that is in no
  // class, and lifting an entry from the back of its class to the front.
  task automatic test_refresh();
    do_update(5'd20, 1'b0, 1'b1, 1'b0, 1'b0);
    do_update(5'd3,  1'b0, 1'b0, 1'b0, 1'b0);
    do_update(5'd9,  1'b0, 1'b1, 1'b0, 1'b1);
  endtask

  // Removing a queued entry, then the same entry once it is no longer queued.
  task automatic test_removal();
    do_remove(5'd12);
    do_remove(5'd12);
  endtask

  // The spare opcode must neither change the store nor give a result.
  task automatic test_unused_opcode();
    send_item(OP_UNUSED, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
  endtask

  // A mask that hides the best entry, a mask that picks one entry deep in a class,
  // then full pops until the store runs dry.
  task automatic test_masked_pops();
    do_pop(~(32'd1 << 31));
    do_pop(32'd1 << 20);
    repeat (5) do_pop(32'hFFFF_FFFF);
  endtask

  // Weighted random traffic. Updates dominate so that the classes fill up and
  // pops find deep, well-populated classes; a middle stretch runs without pauses.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic [4:0]  id;
    logic [31:0] mask;
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 2);
      // A third of the accesses land on a few entries so that they are updated
      // again and again, often while at the front of their class.
      id = ($urandom_range(0, 99) < 33) ? 5'($urandom_range(0, 5)) : 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        mask = 32'hFFFF_FFFF;
      end else if (pick < 65) begin
        mask = $urandom;
      end else if (pick < 85) begin
        mask = $urandom & $urandom & $urandom;
      end else if (pick < 95) begin
        mask = 32'd1 << $urandom_range(0, 31);
      end else begin
        mask = 32'h0000_0000;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        do_update(id, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 78) begin
        do_pop(mask);
      end else if (pick < 94) begin
        do_remove(id);
      end else begin
        send_item(OP_UNUSED, id, 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), mask);
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = apmq_pkg::OP_UPDATE;
    in_entry_id       = '0;
    in_is_dialog      = 1'b0;
    in_flag_highlight = 1'b0;
    in_flag_message   = 1'b0;
    in_flag_data      = 1'b0;
    in_eligible_mask  = '0;
    faults            = 0;
    stall_cycles      = 0;
    steady            = 1'b0;
    // The predictor starts from the reset state: no entry in any class, and each
    // rank equal to the entry's own index.
    for (int i = 0; i < SESSIONS; i++) begin
      seat_class[i] = apmq_pkg::NO_CLASS;
      seat_rank[i]  = i[4:0];
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_classification();
    test_refresh();
    test_removal();
    test_unused_opcode();
    test_masked_pops();
    test_random_traffic(828);

    @(negedge clk);
    start <= 1'b0;
    // Wait for the last pop to be answered, then long enough for a full search
    // to show any stray result; the watchdog bounds both waits.
    while (pop_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SESSIONS + 8) @(posedge clk);

    if (faults == 0 && pop_answers.size() == 0) begin
      $display("activity_priority_mru_queue_tb OK");
    end else begin
      $display("activity_priority_mru_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/apmq_pkg.sv
hw/rtl/apmq_cell.sv
hw/rtl/activity_priority_mru_queue.sv
hw/rtl/apmq_checker.sv
tb/activity_priority_mru_queue_tb.sv
